// File: rtl/core/cutq_pkg.sv
// ----------------------------------------------------------------------------
// cutq_pkg
// Shared types and constants of the CAN to serial frame queue: event codes,
// register indexes, reset values and the packing of the stream words.
// ----------------------------------------------------------------------------
package cutq_pkg;

    // default ring depth (one slot is always kept empty)
    localparam int QUEUE_DEPTH_DEFAULT = 64;

    // event kinds carried in s_tuser
    typedef enum logic [2:0] {
        MODE_CAN_FRAME   = 3'd0,
        MODE_POLL        = 3'd1,
        MODE_SEND_DONE   = 3'd2,
        MODE_SERIAL_ERR  = 3'd3,
        MODE_BUS_STATUS  = 3'd4,
        MODE_STARTUP     = 3'd5
    } mode_t;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TYPE_CODE_A = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TYPE_CODE_B = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEC_THRESH  = 2'd2;
    localparam int CFG_DATA_W = 8;

    // register reset values
    localparam logic [7:0] TYPE_CODE_A_RST = 8'h02;
    localparam logic [7:0] TYPE_CODE_B_RST = 8'h03;
    localparam logic [7:0] TEC_THRESH_RST  = 8'd192;

    // one queued frame: low identifier byte and eight payload bytes
    typedef struct packed {
        logic [63:0] payload;
        logic [7:0]  id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // stream word widths
    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 80;
    localparam int COUNT_W   = 6;

endpackage

// File: rtl/core/cutq_ring_ram.sv
// ----------------------------------------------------------------------------
// cutq_ring_ram
// Frame store of the queue: one write port and one read port with a
// registered read word that holds until the next read.
// ----------------------------------------------------------------------------
module cutq_ring_ram
    import cutq_pkg::*;
#(
    parameter int DEPTH  = QUEUE_DEPTH_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = ENTRY_W
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/can_to_uart_frame_queue.sv
// ----------------------------------------------------------------------------
// can_to_uart_frame_queue
// Queue between a CAN receiver and a serial sender: filters standard data
// frames by payload type byte, keeps them in a ring, and hands the head
// entry out on poll or send-complete events while tracking the link state.
//
//   channel   | ports                        | word
//   ----------+------------------------------+---------------------------------
//   event in  | s_tvalid s_tready s_tdata/u  | one CAN frame or link event
//   result out| m_tvalid m_tready m_tdata/u  | one result per event
//   config    | cfg_valid cfg_ready idx/data | one register write
//
// One event a cycle while s_tready is high; its result comes the cycle after
// acceptance, from the single register stage after ring decode and store read.
// s_tready drops only while a result waits and m_tready is low.
// Reset clears the indexes, flags and registers at once; the frame store
// needs no clearing pass, only written entries are ever read.
// ----------------------------------------------------------------------------
module can_to_uart_frame_queue
    import cutq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // event input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // std_id[10:0], is_extended[11], is_remote[12], payload[76:13],
    // bus_off[77], error_passive[78], tx_error_count[86:79], startup_ok[87]
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // mode[2:0]
    input  logic [S_TUSER_W-1:0]   s_tuser,
    // result output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // frame_id[7:0], frame_payload[71:8], offline[72], queue_count[78:73],
    // dropped[79]
    output logic [M_TDATA_W-1:0]   m_tdata,
    // frame_valid[0]
    output logic                   m_tuser,
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(QUEUE_DEPTH - 1);
    localparam logic [ADDR_W:0]   DEPTH_EXT = (ADDR_W + 1)'(QUEUE_DEPTH);

    // configuration registers
    logic [7:0] type_a_reg;
    logic [7:0] type_b_reg;
    logic [7:0] tec_thresh_reg;

    // queue and link state
    logic [ADDR_W-1:0] wr_idx_reg, wr_idx_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic              busy_reg, busy_next;
    logic              offline_reg, offline_next;

    // result register
    logic               res_valid_reg;
    logic               res_send_reg;
    logic               res_offline_reg;
    logic [COUNT_W-1:0] res_count_reg;
    logic               res_dropped_reg;

    // input fields
    mode_t       in_mode;
    logic [10:0] in_std_id;
    logic        in_is_ext;
    logic        in_is_rem;
    logic [63:0] in_payload;
    logic        in_bus_off;
    logic        in_err_pass;
    logic [7:0]  in_tec;
    logic        in_startup_ok;

    logic        accept;
    logic        frame_ok;
    logic        ring_empty;
    logic        ring_full;
    logic [ADDR_W-1:0] wr_idx_inc;
    logic [ADDR_W-1:0] rd_idx_inc;
    logic        send;
    logic        wr_en;
    logic        dropped;
    entry_t      wr_entry;
    entry_t      rd_entry;
    logic [ENTRY_W-1:0] rd_word;
    logic [ADDR_W:0]    cnt_diff;
    logic [ADDR_W-1:0]  cnt;
    logic [ADDR_W+COUNT_W-1:0] cnt_ext;

    // field unpacking
    assign in_mode       = mode_t'(s_tuser);
    assign in_std_id     = s_tdata[10:0];
    assign in_is_ext     = s_tdata[11];
    assign in_is_rem     = s_tdata[12];
    assign in_payload    = s_tdata[76:13];
    assign in_bus_off    = s_tdata[77];
    assign in_err_pass   = s_tdata[78];
    assign in_tec        = s_tdata[86:79];
    assign in_startup_ok = s_tdata[87];

    // handshakes
    assign s_tready  = !res_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // ring pointers
    assign wr_idx_inc = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + ADDR_W'(1);
    assign rd_idx_inc = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + ADDR_W'(1);
    assign ring_empty = (wr_idx_reg == rd_idx_reg);
    assign ring_full  = (wr_idx_inc == rd_idx_reg);

    // frame filter: standard data frame with a known type byte
    assign frame_ok = !in_is_ext && !in_is_rem &&
                      ((in_payload[7:0] == type_a_reg) || (in_payload[7:0] == type_b_reg));

    // event decode
    always_comb begin
        wr_idx_next  = wr_idx_reg;
        rd_idx_next  = rd_idx_reg;
        busy_next    = busy_reg;
        offline_next = offline_reg;
        send         = 1'b0;
        wr_en        = 1'b0;
        dropped      = 1'b0;
        case (in_mode)
            MODE_CAN_FRAME: begin
                if (frame_ok) begin
                    if (!ring_full) begin
                        wr_en       = accept;
                        wr_idx_next = wr_idx_inc;
                    end else begin
                        dropped = 1'b1;
                    end
                end
            end
            MODE_POLL: begin
                send = !offline_reg && !busy_reg && !ring_empty;
            end
            MODE_SEND_DONE: begin
                busy_next = 1'b0;
                send      = !ring_empty;
            end
            MODE_SERIAL_ERR: begin
                busy_next = 1'b0;
            end
            MODE_BUS_STATUS: begin
                if (in_bus_off || (in_err_pass && (in_tec >= tec_thresh_reg))) begin
                    offline_next = 1'b1;
                end
            end
            MODE_STARTUP: begin
                offline_next = !in_startup_ok;
            end
            default: begin
            end
        endcase
        // a send hands out the head entry and marks the sender busy
        if (send) begin
            busy_next   = 1'b1;
            rd_idx_next = rd_idx_inc;
        end
    end

    // entries waiting after this event
    assign cnt_diff = {1'b0, wr_idx_next} - {1'b0, rd_idx_next};
    assign cnt      = cnt_diff[ADDR_W] ? ADDR_W'(cnt_diff + DEPTH_EXT)
                                       : cnt_diff[ADDR_W-1:0];
    assign cnt_ext  = {{COUNT_W{1'b0}}, cnt};

    assign wr_entry.payload = in_payload;
    assign wr_entry.id      = in_std_id[7:0];

    // frame store
    cutq_ring_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_ring_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx_reg),
        .wr_data (wr_entry),
        .rd_en   (accept && send),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_word)
    );

    assign rd_entry = entry_t'(rd_word);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_a_reg     <= TYPE_CODE_A_RST;
            type_b_reg     <= TYPE_CODE_B_RST;
            tec_thresh_reg <= TEC_THRESH_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TYPE_CODE_A: type_a_reg     <= cfg_data;
                CFG_TYPE_CODE_B: type_b_reg     <= cfg_data;
                CFG_TEC_THRESH:  tec_thresh_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // queue and link state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            busy_reg    <= 1'b0;
            offline_reg <= 1'b0;
        end else if (accept) begin
            wr_idx_reg  <= wr_idx_next;
            rd_idx_reg  <= rd_idx_next;
            busy_reg    <= busy_next;
            offline_reg <= offline_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (s_tready) begin
            res_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_send_reg    <= send;
            res_offline_reg <= offline_next;
            res_count_reg   <= cnt_ext[COUNT_W-1:0];
            res_dropped_reg <= dropped;
        end
    end

    // output packing, frame fields zero when nothing is sent
    assign m_tvalid = res_valid_reg;
    assign m_tuser  = res_send_reg;
    assign m_tdata  = {res_dropped_reg, res_count_reg, res_offline_reg,
                       res_send_reg ? rd_entry.payload : 64'd0,
                       res_send_reg ? rd_entry.id : 8'd0};

    // nothing leaves an empty ring
    a_no_send_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ring_empty) |=> !res_send_reg)
        else $error("send issued from an empty ring");

    // a poll never sends while the link is offline
    a_poll_offline: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_mode == MODE_POLL) && offline_reg) |=> !res_send_reg)
        else $error("poll sent while offline");

    // every send leaves the sender busy
    a_busy_after_send: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && send) |=> busy_reg)
        else $error("sender not busy after a send");

    // a store write never lands on the slot being read
    a_rw_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && accept && send) |-> (wr_idx_reg != rd_idx_reg))
        else $error("frame store write and read collide");

    // a stored frame never overruns the head
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && wr_en) |=> (wr_idx_reg != rd_idx_reg))
        else $error("ring write overran the head");

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the CAN to serial frame queue. A short table of events
// with hand-worked results opens the run, followed by phases of random
// traffic (frame floods, send-complete drains, link events) under several
// filter and error-threshold settings. Every result word is checked field by
// field against its table result or an in-bench model of ring and link state.
// ----------------------------------------------------------------------------
module tb_top
    import cutq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_SLOTS  = QUEUE_DEPTH_DEFAULT;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 238;

    // event kinds with no meaning to the block
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {
        MIX_FLOOD,
        MIX_DRAIN,
        MIX_BLEND
    } traffic_mix_t;

    // one input event, fields as the block sees them
    typedef struct packed {
        logic [2:0]  mode;
        logic [10:0] std_id;
        logic        ext;
        logic        rtr;
        logic [63:0] payload;
        logic        bus_off;
        logic        err_passive;
        logic [7:0]  tec;
        logic        startup_ok;
    } can_event_t;

    // one result word
    typedef struct packed {
        logic        sent;
        logic [7:0]  id;
        logic [63:0] payload;
        logic        offline;
        logic [5:0]  count;
        logic        dropped;
    } bridge_result_t;

    typedef struct packed {
        can_event_t     ev;
        logic           typed;
        bridge_result_t want;
    } directed_row_t;

    localparam bridge_result_t UNTYPED = '0;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // model state: filter settings, ring and link flags
    logic [7:0] match_code_a = TYPE_CODE_A_RST;
    logic [7:0] match_code_b = TYPE_CODE_B_RST;
    logic [7:0] tec_limit    = TEC_THRESH_RST;
    entry_t     ring_store [RING_SLOTS];
    int         fill_idx     = 0;
    int         drain_idx    = 0;
    bit         tx_busy      = 1'b0;
    bit         link_down    = 1'b0;

    bridge_result_t pending_results [$];
    int             results_seen = 0;
    int             mismatches   = 0;
    bit             hold_req     = 1'b0;

    // hand-worked opening sequence, reset register values
    directed_row_t directed_rows [25] = '{
        // poll with nothing queued
        '{'{MODE_POLL, 11'h000, 1'b0, 1'b0, 64'h0, 1'b0, 1'b0, 8'h00, 1'b0},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b0, 6'd0, 1'b0}},
        // frames of both type codes, identifier extremes
        '{'{MODE_CAN_FRAME, 11'h7FF, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FF02,
            1'b0, 1'b0, 8'h00, 1'b0},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b0, 6'd1, 1'b0}},
        '{'{MODE_CAN_FRAME, 11'h000, 1'b0, 1'b0, 64'h0000_0000_0000_0003,
            1'b0, 1'b0, 8'h00, 1'b0},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b0, 6'd2, 1'b0}},
        // extended, remote and foreign-type frames are ignored
        '{'{MODE_CAN_FRAME, 11'h123, 1'b1, 1'b0, 64'h1111_2222_3333_4402,
            1'b0, 1'b0, 8'h00, 1'b0},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b0, 6'd2, 1'b0}},
        '{'{MODE_CAN_FRAME, 11'h456, 1'b0, 1'b1, 64'h5555_6666_7777_8803,
            1'b0, 1'b0, 8'h00, 1'b0},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b0, 6'd2, 1'b0}},
        '{'{MODE_CAN_FRAME, 11'h3C3, 1'b0, 1'b0, 64'hA5A5_A5A5_A5A5_A504,
            1'b0, 1'b0, 8'h00, 1'b0},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b0, 6'd2, 1'b0}},
        // poll sends the head, a second poll finds the sender busy
        '{'{MODE_POLL, 11'h000, 1'b0, 1'b0, 64'h0, 1'b0, 1'b0, 8'h00, 1'b0},
          1'b1, '{1'b1, 8'hFF, 64'hFFFF_FFFF_FFFF_FF02, 1'b0, 6'd1, 1'b0}},
        '{'{MODE_POLL, 11'h000, 1'b0, 1'b0, 64'h0, 1'b0, 1'b0, 8'h00, 1'b0},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b0, 6'd1, 1'b0}},
        // send complete chains the next entry
        '{'{MODE_SEND_DONE, 11'h000, 1'b0, 1'b0, 64'h0, 1'b0, 1'b0, 8'h00, 1'b0},
          1'b1, '{1'b1, 8'h00, 64'h0000_0000_0000_0003, 1'b0, 6'd0, 1'b0}},
        '{'{MODE_SERIAL_ERR, 11'h000, 1'b0, 1'b0, 64'h0, 1'b0, 1'b0, 8'h00, 1'b0},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b0, 6'd0, 1'b0}},
        '{'{MODE_SEND_DONE, 11'h000, 1'b0, 1'b0, 64'h0, 1'b0, 1'b0, 8'h00, 1'b0},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b0, 6'd0, 1'b0}},
        // bus-off, then error-passive just below and at the threshold
        '{'{MODE_BUS_STATUS, 11'h000, 1'b0, 1'b0, 64'h0, 1'b1, 1'b0, 8'h00, 1'b0},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b1, 6'd0, 1'b0}},
        '{'{MODE_STARTUP, 11'h000, 1'b0, 1'b0, 64'h0, 1'b0, 1'b0, 8'h00, 1'b1},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b0, 6'd0, 1'b0}},
        '{'{MODE_BUS_STATUS, 11'h000, 1'b0, 1'b0, 64'h0, 1'b0, 1'b1, 8'd191, 1'b0},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b0, 6'd0, 1'b0}},
        '{'{MODE_BUS_STATUS, 11'h000, 1'b0, 1'b0, 64'h0, 1'b0, 1'b1, 8'd192, 1'b0},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b1, 6'd0, 1'b0}},
        // offline: poll holds back, send complete still chains
        '{'{MODE_CAN_FRAME, 11'h5A5, 1'b0, 1'b0, 64'h0123_4567_89AB_CD02,
            1'b0, 1'b0, 8'h00, 1'b0},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b1, 6'd1, 1'b0}},
        '{'{MODE_POLL, 11'h000, 1'b0, 1'b0, 64'h0, 1'b0, 1'b0, 8'h00, 1'b0},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b1, 6'd1, 1'b0}},
        '{'{MODE_SEND_DONE, 11'h000, 1'b0, 1'b0, 64'h0, 1'b0, 1'b0, 8'h00, 1'b0},
          1'b1, '{1'b1, 8'hA5, 64'h0123_4567_89AB_CD02, 1'b1, 6'd0, 1'b0}},
        // startup result both ways
        '{'{MODE_STARTUP, 11'h000, 1'b0, 1'b0, 64'h0, 1'b0, 1'b0, 8'h00, 1'b1},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b0, 6'd0, 1'b0}},
        '{'{MODE_STARTUP, 11'h000, 1'b0, 1'b0, 64'h0, 1'b0, 1'b0, 8'h00, 1'b0},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b1, 6'd0, 1'b0}},
        '{'{MODE_STARTUP, 11'h000, 1'b0, 1'b0, 64'h0, 1'b0, 1'b0, 8'h00, 1'b1},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b0, 6'd0, 1'b0}},
        // status with neither condition never clears or sets offline
        '{'{MODE_BUS_STATUS, 11'h7FF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
            1'b0, 1'b0, 8'hFF, 1'b1},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b0, 6'd0, 1'b0}},
        // spare kinds change nothing
        '{'{MODE_SPARE_6, 11'h7FF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
            1'b1, 1'b1, 8'hFF, 1'b0},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b0, 6'd0, 1'b0}},
        '{'{MODE_SPARE_7, 11'h7FF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
            1'b1, 1'b1, 8'hFF, 1'b0},
          1'b1, '{1'b0, 8'h00, 64'h0, 1'b0, 6'd0, 1'b0}},
        // frame with the status fields set, left to the model
        '{'{MODE_CAN_FRAME, 11'h7FF, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FF03,
            1'b1, 1'b1, 8'hFF, 1'b1},
          1'b0, UNTYPED}
    };

    can_to_uart_frame_queue dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // hand the head entry to the sender, if any
    function automatic void hand_out_head(inout bridge_result_t r);
        if (fill_idx == drain_idx) return;
        r.sent    = 1'b1;
        r.id      = ring_store[drain_idx].id;
        r.payload = ring_store[drain_idx].payload;
        tx_busy   = 1'b1;
        drain_idx = (drain_idx + 1) % RING_SLOTS;
    endfunction

    // result of one event, advancing the ring and link state
    function automatic bridge_result_t bridge_step(input can_event_t ev);
        bridge_result_t r;
        int nxt;
        r = '0;
        case (ev.mode)
            MODE_CAN_FRAME: begin
                if (!ev.ext && !ev.rtr &&
                    (ev.payload[7:0] == match_code_a || ev.payload[7:0] == match_code_b)) begin
                    nxt = (fill_idx + 1) % RING_SLOTS;
                    if (nxt != drain_idx) begin
                        ring_store[fill_idx].id      = ev.std_id[7:0];
                        ring_store[fill_idx].payload = ev.payload;
                        fill_idx = nxt;
                    end else begin
                        r.dropped = 1'b1;
                    end
                end
            end
            MODE_POLL: begin
                if (!link_down && !tx_busy) hand_out_head(r);
            end
            MODE_SEND_DONE: begin
                tx_busy = 1'b0;
                hand_out_head(r);
            end
            MODE_SERIAL_ERR: tx_busy = 1'b0;
            MODE_BUS_STATUS: begin
                // bus-off first, then error-passive at or over the limit
                if (ev.bus_off) link_down = 1'b1;
                else if (ev.err_passive && ev.tec >= tec_limit) link_down = 1'b1;
            end
            MODE_STARTUP: link_down = !ev.startup_ok;
            default: ;
        endcase
        r.offline = link_down;
        r.count   = 6'((fill_idx + RING_SLOTS - drain_idx) % RING_SLOTS);
        return r;
    endfunction

    // gap length: mostly none, some short, a few long
    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        // keep the log short on a badly broken build
        if (mismatches <= 100)
            $display("%0t ns: word %0d %s: got 0x%0h, want 0x%0h",
                     $time, results_seen, what, got, want);
    endtask

    // offer one event word and queue what it should give back
    task automatic offer_event(input can_event_t ev, input bit typed,
                               input bridge_result_t typed_want);
        bridge_result_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= ev.mode;
        s_tdata  <= {ev.startup_ok, ev.tec, ev.err_passive, ev.bus_off,
                     ev.payload, ev.rtr, ev.ext, ev.std_id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = bridge_step(ev);
        pending_results.push_back(typed ? typed_want : predicted);
    endtask

    // register write; the caller lowers cfg_valid after the last one
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_TYPE_CODE_A: match_code_a = value;
            CFG_TYPE_CODE_B: match_code_b = value;
            CFG_TEC_THRESH:  tec_limit    = value;
            default: ;
        endcase
    endtask

    // stop offering and wait for every outstanding word
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // event source
    initial begin : event_source
        can_event_t   ev;
        traffic_mix_t mix;
        int           burst_left;
        bit           burst_quiet;
        int           roll;
        int           gap;
        logic [7:0]   code_a;
        logic [7:0]   code_b;
        logic [7:0]   thresh;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            offer_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);

        for (int phase = 0; phase < PHASES; phase++) begin
            settle_idle();
            // new filter and threshold settings while idle
            if (phase > 0) begin
                case (phase)
                    1: begin code_a = 8'h00; code_b = 8'hFF; thresh = 8'd0; end
                    2: begin code_a = 8'hFF; code_b = 8'h00; thresh = 8'd255; end
                    3: begin
                        code_a = 8'($urandom);
                        code_b = code_a;
                        thresh = 8'($urandom);
                    end
                    4: begin
                        code_a = TYPE_CODE_A_RST;
                        code_b = TYPE_CODE_B_RST;
                        thresh = TEC_THRESH_RST;
                    end
                    default: begin
                        code_a = 8'($urandom);
                        code_b = 8'($urandom);
                        thresh = 8'd1;
                    end
                endcase
                write_reg(CFG_TYPE_CODE_A, code_a);
                write_reg(CFG_TYPE_CODE_B, code_b);
                write_reg(CFG_TEC_THRESH, thresh);
                cfg_valid <= 1'b0;
                @(posedge aclk);
            end
            // long receiver hold while words keep coming
            if (phase == 3) hold_req = 1'b1;

            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (burst_left == 0) begin
                    mix         = traffic_mix_t'($urandom_range(0, 2));
                    burst_quiet = ($urandom_range(0, 3) == 0);
                    burst_left  = (mix == MIX_FLOOD) ? $urandom_range(90, 140)
                                                     : $urandom_range(20, 80);
                end
                burst_left--;

                // every field random, then shaped by event kind
                ev.std_id      = 11'($urandom);
                ev.ext         = 1'($urandom);
                ev.rtr         = 1'($urandom);
                ev.payload     = {$urandom, $urandom};
                ev.bus_off     = 1'($urandom);
                ev.err_passive = 1'($urandom);
                ev.tec         = 8'($urandom);
                ev.startup_ok  = 1'($urandom);

                roll = $urandom_range(0, 99);
                case (mix)
                    MIX_FLOOD: begin
                        if (roll < 85)      ev.mode = MODE_CAN_FRAME;
                        else if (roll < 90) ev.mode = MODE_POLL;
                        else if (roll < 95) ev.mode = MODE_SEND_DONE;
                        else                ev.mode = 3'($urandom_range(3, 7));
                    end
                    MIX_DRAIN: begin
                        if (roll < 20)      ev.mode = MODE_CAN_FRAME;
                        else if (roll < 75) ev.mode = MODE_SEND_DONE;
                        else if (roll < 85) ev.mode = MODE_POLL;
                        else if (roll < 90) ev.mode = MODE_SERIAL_ERR;
                        else if (roll < 95) ev.mode = MODE_STARTUP;
                        else                ev.mode = MODE_BUS_STATUS;
                    end
                    default: begin
                        if (roll < 35)      ev.mode = MODE_CAN_FRAME;
                        else if (roll < 50) ev.mode = MODE_POLL;
                        else if (roll < 70) ev.mode = MODE_SEND_DONE;
                        else if (roll < 75) ev.mode = MODE_SERIAL_ERR;
                        else if (roll < 85) ev.mode = MODE_BUS_STATUS;
                        else if (roll < 95) ev.mode = MODE_STARTUP;
                        else                ev.mode = $urandom_range(0, 1) ? MODE_SPARE_6
                                                                          : MODE_SPARE_7;
                    end
                endcase

                case (ev.mode)
                    MODE_CAN_FRAME: begin
                        // mostly well-formed frames of an accepted type
                        if ($urandom_range(0, 9) != 0) begin
                            ev.payload[7:0] = $urandom_range(0, 1) ? match_code_a
                                                                   : match_code_b;
                            ev.ext = ($urandom_range(0, 15) == 0);
                            ev.rtr = ($urandom_range(0, 15) == 0);
                        end
                    end
                    MODE_BUS_STATUS: begin
                        ev.bus_off = ($urandom_range(0, 7) == 0);
                        if ($urandom_range(0, 3) == 0)
                            ev.tec = tec_limit - 8'($urandom_range(0, 1));
                    end
                    MODE_STARTUP: ev.startup_ok = ($urandom_range(0, 4) != 0);
                    default: ;
                endcase

                offer_event(ev, 1'b0, UNTYPED);

                gap = (burst_quiet || phase == 3) ? 0 : idle_cycles();
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                // now and then wait for the block to empty out
                if ($urandom_range(0, 199) == 0) settle_idle();
            end
        end

        settle_idle();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("can_to_uart_frame_queue: match");
        end else begin
            $display("can_to_uart_frame_queue: mismatch");
        end
        $finish;
    end

    // result sink: ready pattern and field checks
    initial begin : result_sink
        bridge_result_t got;
        bridge_result_t want;
        int             hold_left;
        int             stall_left;
        int             stretch_left;
        bit             steady;

        hold_left    = 0;
        stall_left   = 0;
        stretch_left = 0;
        steady       = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                results_seen++;
                got = {m_tuser, m_tdata[7:0], m_tdata[71:8], m_tdata[72],
                       m_tdata[78:73], m_tdata[79]};
                if (pending_results.size() == 0) begin
                    report_mismatch("word with nothing pending", got.payload, 64'h0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.sent != want.sent)
                        report_mismatch("frame_valid", got.sent, want.sent);
                    if (got.id != want.id)
                        report_mismatch("frame_id", got.id, want.id);
                    if (got.payload != want.payload)
                        report_mismatch("frame_payload", got.payload, want.payload);
                    if (got.offline != want.offline)
                        report_mismatch("offline", got.offline, want.offline);
                    if (got.count != want.count)
                        report_mismatch("queue_count", got.count, want.count);
                    if (got.dropped != want.dropped)
                        report_mismatch("dropped", got.dropped, want.dropped);
                end
            end

            // stretches of steady readiness between stretches of stalls
            if (stretch_left == 0) begin
                stretch_left = 64;
                steady       = ($urandom_range(0, 2) == 0);
            end
            stretch_left--;
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end

            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                stall_left = steady ? 0 : (($urandom_range(0, 2) == 0) ? idle_cycles() : 0);
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // run limit
    initial begin
        #10_000_000;
        $display("can_to_uart_frame_queue: mismatch");
        $finish;
    end

endmodule
